### hw/rtl/lgpf_pkg.sv
// Shared constants, types and codes for the lamp glow persistence filter.
// Used by every module of the block except lgpf_ram; depends on nothing.
package lgpf_pkg;

  localparam int SAMPLES       = 1024;   // snapshots per window, power of two
  localparam int ROWS          = 7;
  localparam int LAMPS_PER_ROW = 18;

  localparam int MAX_ROWS   = 7;
  localparam int MAX_LAMPS  = 18;
  localparam int HALF_LAMPS = 9;

  localparam int USED_ROWS  = (ROWS < MAX_ROWS) ? ROWS : MAX_ROWS;
  localparam int USED_LAMPS = (LAMPS_PER_ROW < MAX_LAMPS) ? LAMPS_PER_ROW : MAX_LAMPS;
  localparam int NUM_LAMPS  = USED_ROWS * USED_LAMPS;

  localparam int SAMPLE_SHIFT = $clog2(SAMPLES);
  localparam int SCNT_W       = SAMPLE_SHIFT;
  localparam int CNT_W        = SAMPLE_SHIFT + 1;
  localparam int ADDR_W       = (NUM_LAMPS > 1) ? $clog2(NUM_LAMPS) : 1;
  localparam int J_W          = $clog2(HALF_LAMPS);
  localparam int LIDX_W       = $clog2(MAX_LAMPS + 1);

  localparam int INT_W     = 17;
  localparam int ONE_Q16   = 65536;
  localparam int HALF_Q16  = 32768;
  localparam int LEVEL_W   = 5;
  localparam int LEVEL_MAX = 31;
  localparam int ROW_W     = 3;

  localparam int IN_DATA_W  = ((MAX_ROWS * MAX_LAMPS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((HALF_LAMPS * LEVEL_W + 7) / 8) * 8;
  localparam int USER_W     = ROW_W + 1;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_RISE_KEEP = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FALL_KEEP = CFG_IDX_W'(1);

  localparam logic [CFG_DATA_W-1:0] RISE_KEEP_RST = CFG_DATA_W'(64750);
  localparam logic [CFG_DATA_W-1:0] FALL_KEEP_RST = CFG_DATA_W'(65208);

  typedef logic [CNT_W-1:0]   count_t;
  typedef logic [INT_W-1:0]   inten_t;
  typedef logic [LEVEL_W-1:0] level_t;

  // Count queue status toward the back end
  typedef struct packed {
    logic   full;
    count_t head;
  } q_stat_t;

  // Back end requests to the count queue
  typedef struct packed {
    logic pop;
    logic done;
  } q_ctrl_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_RUN,
    B_DRAIN,
    B_EMIT
  } back_state_t;

endpackage

### hw/rtl/lgpf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lgpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/lgpf_front.sv
// Front end: accepts panel snapshots, counts on-samples per lamp in parallel
// and hands a full window of counts to the count queue. Uses lgpf_pkg.
module lgpf_front (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       s_tvalid,
  output logic                                       s_tready,
  input  logic [lgpf_pkg::IN_DATA_W-1:0]             s_tdata,
  input  logic                                       q_full,
  output logic                                       push,
  output lgpf_pkg::count_t [lgpf_pkg::NUM_LAMPS-1:0] snap
);
  import lgpf_pkg::*;

  logic [SCNT_W-1:0]       sample_cnt;
  count_t [NUM_LAMPS-1:0]  on_cnt;
  logic [NUM_LAMPS-1:0]    bits;
  logic                    window_end;
  logic                    accept;

  for (genvar r = 0; r < USED_ROWS; r++) begin : g_row
    for (genvar l = 0; l < USED_LAMPS; l++) begin : g_lamp
      assign bits[r*USED_LAMPS+l] = s_tdata[r*MAX_LAMPS+l];
    end
  end

  for (genvar i = 0; i < NUM_LAMPS; i++) begin : g_cnt
    assign snap[i] = on_cnt[i] + CNT_W'(bits[i]);
  end

  assign window_end = (sample_cnt == SCNT_W'(SAMPLES - 1));
  // hold the window's last snapshot until the queue has room for its counts
  assign s_tready   = !(window_end && q_full);
  assign accept     = s_tvalid && s_tready;
  assign push       = accept && window_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_cnt <= '0;
      on_cnt     <= '0;
    end else if (accept) begin
      if (window_end) begin
        sample_cnt <= '0;
        on_cnt     <= '0;
      end else begin
        sample_cnt <= sample_cnt + SCNT_W'(1);
        on_cnt     <= snap;
      end
    end
  end

endmodule

### hw/rtl/lgpf_queue.sv
// One-window count queue between front and back end. The entry is a shift
// line: the back end takes the head and advances it. Uses lgpf_pkg.
module lgpf_queue (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       push,
  input  lgpf_pkg::count_t [lgpf_pkg::NUM_LAMPS-1:0] snap,
  input  lgpf_pkg::q_ctrl_t                          ctrl,
  output lgpf_pkg::q_stat_t                          stat
);
  import lgpf_pkg::*;

  count_t [NUM_LAMPS-1:0] entry;
  logic                   full;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (push) begin
      full <= 1'b1;
    end else if (ctrl.done) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry <= snap;
    end else if (ctrl.pop) begin
      entry <= entry >> CNT_W;
    end
  end

  assign stat.full = full;
  assign stat.head = entry[0];

endmodule

### hw/rtl/lgpf_back.sv
// Back end: walks the queued window lamp by lamp through the smoothing
// pipeline, keeps intensities in RAM and emits half-row level results.
// Uses lgpf_pkg and lgpf_ram.
module lgpf_back (
  input  logic                                clk,
  input  logic                                rst,
  input  lgpf_pkg::q_stat_t                   stat,
  output lgpf_pkg::q_ctrl_t                   ctrl,
  input  logic [lgpf_pkg::CFG_DATA_W-1:0]     rise_keep,
  input  logic [lgpf_pkg::CFG_DATA_W-1:0]     fall_keep,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [lgpf_pkg::OUT_DATA_W-1:0]     m_tdata,   // level_0 .. level_8
  output logic [lgpf_pkg::USER_W-1:0]         m_tuser,   // row_index, half_select
  output logic                                m_tlast    // last_of_frame
);
  import lgpf_pkg::*;

  back_state_t state, state_next;

  logic [J_W-1:0]    j;
  logic [ROW_W-1:0]  row;
  logic              half;
  logic [ADDR_W-1:0] lamp_addr;
  logic [LIDX_W-1:0] lamp_idx;
  logic              lamp_used;
  logic              issue;
  logic              pipe_busy;
  logic              out_free;
  logic              last_half;
  logic              load_out;
  logic              start_window;
  logic              next_half;

  logic [NUM_LAMPS-1:0] inten_vld;
  inten_t               ram_rdata;

  // stage 1: RAM data back, form target and products
  logic              p1_vld;
  logic [J_W-1:0]    p1_j;
  logic [ADDR_W-1:0] p1_addr;
  count_t            p1_cnt;
  logic              p1_ivld;
  inten_t            cur;
  logic [CNT_W+15:0] targ_w;
  inten_t            targ;
  logic              rising;
  inten_t            keep_sel;
  inten_t            k;
  inten_t            k_rest;
  logic [2*INT_W-1:0] prod_a;
  logic [2*INT_W-1:0] prod_b;

  // stage 2: sum, round, write back
  logic               p2_vld;
  logic [J_W-1:0]     p2_j;
  logic [ADDR_W-1:0]  p2_addr;
  logic [2*INT_W-1:0] p2_pa;
  logic [2*INT_W-1:0] p2_pb;
  logic [2*INT_W:0]   sum;
  logic [INT_W+1:0]   sum_sh;
  inten_t             new_i;

  // stage 3: level
  logic               p3_vld;
  logic [J_W-1:0]     p3_j;
  inten_t             p3_i;
  logic [INT_W+4:0]   lvl_w;
  logic [INT_W+4-16:0] lvl_sh;
  level_t             lvl;

  level_t [HALF_LAMPS-1:0] levels;

  // ---------------- sequencer ----------------
  assign lamp_idx  = (half ? LIDX_W'(HALF_LAMPS) : LIDX_W'(0)) + LIDX_W'(j);
  assign lamp_used = (lamp_idx < LIDX_W'(USED_LAMPS));
  assign pipe_busy = p1_vld || p2_vld || p3_vld;
  assign out_free  = !m_tvalid || m_tready;
  assign last_half = (row == ROW_W'(USED_ROWS - 1)) && half;

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE:  if (stat.full) state_next = B_RUN;
      B_RUN:   if (j == J_W'(HALF_LAMPS - 1)) state_next = B_DRAIN;
      B_DRAIN: if (!pipe_busy) state_next = B_EMIT;
      B_EMIT: begin
        if (out_free) state_next = last_half ? B_IDLE : B_RUN;
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    issue        = 1'b0;
    load_out     = 1'b0;
    start_window = 1'b0;
    unique case (state)
      B_IDLE:  start_window = stat.full;
      B_RUN:   issue = lamp_used;
      B_DRAIN: ;
      B_EMIT:  load_out = out_free;
      default: ;
    endcase
    next_half = load_out && !last_half;
    ctrl.pop  = issue;
    ctrl.done = load_out && last_half;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start_window) begin
      row       <= '0;
      half      <= 1'b0;
      j         <= '0;
      lamp_addr <= '0;
    end else if (state == B_RUN) begin
      j <= j + J_W'(1);
      if (issue) begin
        lamp_addr <= lamp_addr + ADDR_W'(1);
      end
    end else if (next_half) begin
      j    <= '0;
      half <= !half;
      if (half) begin
        row <= row + ROW_W'(1);
      end
    end
  end

  // ---------------- intensity store ----------------
  lgpf_ram #(
    .WIDTH (INT_W),
    .DEPTH (NUM_LAMPS)
  ) u_inten_ram (
    .clk   (clk),
    .we    (p2_vld),
    .waddr (p2_addr),
    .wdata (new_i),
    .re    (issue),
    .raddr (lamp_addr),
    .rdata (ram_rdata)
  );

  // a lamp never written since reset reads as zero intensity
  always_ff @(posedge clk) begin
    if (rst) begin
      inten_vld <= '0;
    end else if (p2_vld) begin
      inten_vld[p2_addr] <= 1'b1;
    end
  end

  // ---------------- pipeline ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld <= 1'b0;
      p2_vld <= 1'b0;
      p3_vld <= 1'b0;
    end else begin
      p1_vld <= issue;
      p2_vld <= p1_vld;
      p3_vld <= p2_vld;
    end
  end

  always_ff @(posedge clk) begin
    p1_j    <= j;
    p1_addr <= lamp_addr;
    p1_cnt  <= stat.head;
    p1_ivld <= inten_vld[lamp_addr];
    p2_j    <= p1_j;
    p2_addr <= p1_addr;
    p2_pa   <= prod_a;
    p2_pb   <= prod_b;
    p3_j    <= p2_j;
    p3_i    <= new_i;
  end

  always_comb begin
    cur      = p1_ivld ? ram_rdata : '0;
    // count * 65536 / SAMPLES is exact for a power-of-two window
    targ_w   = {p1_cnt, 16'b0} >> SAMPLE_SHIFT;
    targ     = (targ_w > (CNT_W + 16)'(ONE_Q16)) ? INT_W'(ONE_Q16) : targ_w[INT_W-1:0];
    rising   = (targ >= cur);
    keep_sel = rising ? rise_keep : fall_keep;
    k        = (keep_sel > INT_W'(ONE_Q16)) ? INT_W'(ONE_Q16) : keep_sel;
    k_rest   = INT_W'(ONE_Q16) - k;
    prod_a   = (2*INT_W)'(cur) * (2*INT_W)'(k);
    prod_b   = rising ? ((2*INT_W)'(targ) * (2*INT_W)'(k_rest)) : '0;
  end

  always_comb begin
    sum    = (2*INT_W+1)'(p2_pa) + (2*INT_W+1)'(p2_pb) + (2*INT_W+1)'(HALF_Q16);
    sum_sh = sum[2*INT_W:16];
    new_i  = (sum_sh > (INT_W+2)'(ONE_Q16)) ? INT_W'(ONE_Q16) : sum_sh[INT_W-1:0];
  end

  always_comb begin
    // intensity * 31, rounded to the nearest level
    lvl_w  = {p3_i, 5'b0} - (INT_W+5)'(p3_i) + (INT_W+5)'(HALF_Q16);
    lvl_sh = lvl_w[INT_W+4:16];
    lvl    = (lvl_sh > (INT_W+5-16)'(LEVEL_MAX)) ? LEVEL_W'(LEVEL_MAX) : lvl_sh[LEVEL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (start_window || next_half) begin
      levels <= '0;
    end else if (p3_vld) begin
      levels[p3_j] <= lvl;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= OUT_DATA_W'(levels);
      m_tuser <= {half, row};
      m_tlast <= last_half;
    end
  end

endmodule

### hw/rtl/lamp_glow_persistence_filter.sv
// Top level of the lamp glow persistence filter: configuration registers, front end,
// count queue and back end. Uses lgpf_pkg, lgpf_front, lgpf_queue and lgpf_back.
//
// Use:
//   s_* takes one panel snapshot per request, 7 rows of 18 on-bits.
//   m_* gives half-row brightness results: tuser = {half_select, row_index},
//   tdata = nine 5-bit levels, tlast on the fourteenth result of a window.
//   cfg_* writes rise_keep (index 0) and fall_keep (index 1), Q1.16; other
//   indexes are ignored. Write only while the block is idle.
// Throughput: one snapshot per cycle while s_tready is high. Every 1024th
// snapshot closes a window and moves its counts into a one-window queue.
// The back end runs each half row through its issue, drain and emit states,
// through its three-stage smoothing pipeline and intensity RAM port, while
// the front end already counts the next window.
// Stalls: a result waits in the output register while the next half row is
// computed. If the receiver holds off so long that the next window closes before
// the previous window's last result is loaded, s_tready drops on that snapshot.
// Reset clears counts, intensities, the window position and loads the default
// coefficients.
module lamp_glow_persistence_filter (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [lgpf_pkg::IN_DATA_W-1:0]      s_tdata,   // lights_row0 .. lights_row6
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [lgpf_pkg::OUT_DATA_W-1:0]     m_tdata,   // level_0 .. level_8
  output logic [lgpf_pkg::USER_W-1:0]         m_tuser,   // row_index, half_select
  output logic                                m_tlast,   // last_of_frame
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lgpf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lgpf_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import lgpf_pkg::*;

  logic [CFG_DATA_W-1:0]  rise_keep;
  logic [CFG_DATA_W-1:0]  fall_keep;
  logic                   push;
  count_t [NUM_LAMPS-1:0] snap;
  q_stat_t                q_stat;
  q_ctrl_t                q_ctrl;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rise_keep <= RISE_KEEP_RST;
      fall_keep <= FALL_KEEP_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_RISE_KEEP: rise_keep <= cfg_data;
        REG_FALL_KEEP: fall_keep <= cfg_data;
        default: ;
      endcase
    end
  end

  lgpf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_full   (q_stat.full),
    .push     (push),
    .snap     (snap)
  );

  lgpf_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .snap (snap),
    .ctrl (q_ctrl),
    .stat (q_stat)
  );

  lgpf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .stat      (q_stat),
    .ctrl      (q_ctrl),
    .rise_keep (rise_keep),
    .fall_keep (fall_keep),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

### hw/rtl/lgpf_checker.sv
// Port-level checks for the lamp glow persistence filter, bound to the top.
// Uses lgpf_pkg.
module lgpf_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [lgpf_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic [lgpf_pkg::USER_W-1:0]     m_tuser,
  input logic                            m_tlast
);
  import lgpf_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("result changed while stalled");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser[ROW_W-1:0] <= ROW_W'(USED_ROWS - 1))
    else $error("row index beyond panel");

  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == ((m_tuser[ROW_W-1:0] == ROW_W'(USED_ROWS - 1))
      && m_tuser[ROW_W])))
    else $error("frame end flag on wrong half row");

  a_rst_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind lamp_glow_persistence_filter lgpf_checker u_lgpf_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

### bench/lamp_glow_persistence_filter_test.sv
`timescale 1ns / 1ps
// Self-checking bench for lamp_glow_persistence_filter: random duty-cycle panel snapshots,
// an in-bench smoothing predictor, random idling on both streams and coefficient sweeps.
// Depends on lgpf_pkg and the lamp_glow_persistence_filter RTL only.
module lamp_glow_persistence_filter_test;
  import lgpf_pkg::*;

  localparam int IDLE_MAX     = 18;
  localparam int SETTLE_CYCLES = 250;    // margin for the back end to finish a window
  localparam int HOLD_CYCLES  = 1800;    // long enough for a whole second window to close
  localparam int QUIET_LIMIT  = 20000;
  localparam int REPORT_MAX   = 10;
  localparam int KEEP_TOP     = (1 << CFG_DATA_W) - 1;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LAST  = '1;

  typedef logic [MAX_LAMPS-1:0] lamp_row_t;
  typedef lamp_row_t [MAX_ROWS-1:0] snapshot_t;

  typedef struct packed {
    logic [ROW_W-1:0]          row;
    logic                      half;
    level_t [HALF_LAMPS-1:0]   lvl;
    logic                      last;
  } half_row_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [IN_DATA_W-1:0]    s_tdata = '0;
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic [OUT_DATA_W-1:0]   m_tdata;
  logic [USER_W-1:0]       m_tuser;
  logic                    m_tlast;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;

  // predictor state
  count_t                  hits [MAX_ROWS][MAX_LAMPS] = '{default: '0};
  inten_t                  glow [MAX_ROWS][MAX_LAMPS] = '{default: '0};
  int unsigned             window_pos = 0;
  logic [CFG_DATA_W-1:0]   keep_up = RISE_KEEP_RST;
  logic [CFG_DATA_W-1:0]   keep_down = FALL_KEEP_RST;
  half_row_t               due_half_rows [$];

  int unsigned             duty [MAX_ROWS][MAX_LAMPS] = '{default: 0};
  int unsigned             mismatches = 0;
  bit                      src_burst = 1'b0;
  bit                      sink_burst = 1'b0;
  bit                      hold_req = 1'b0;
  bit                      hold_seen = 1'b0;
  int unsigned             hold_left = 0;
  int unsigned             sink_wait = 0;

  lamp_glow_persistence_filter i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic inten_t next_glow(inten_t cur, count_t cnt);
    longint unsigned goal, keep, acc, c;
    c = cur;
    goal = (longint'(cnt) * ONE_Q16 + SAMPLES / 2) / SAMPLES;
    if (goal > ONE_Q16) goal = ONE_Q16;
    if (goal >= c) begin
      keep = (keep_up > ONE_Q16) ? ONE_Q16 : keep_up;
      acc = (c * keep + goal * (ONE_Q16 - keep) + HALF_Q16) >> 16;
    end else begin
      keep = (keep_down > ONE_Q16) ? ONE_Q16 : keep_down;
      acc = (c * keep + HALF_Q16) >> 16;
    end
    if (acc > ONE_Q16) acc = ONE_Q16;
    return inten_t'(acc);
  endfunction

  function automatic level_t glow_level(inten_t g);
    longint unsigned v;
    v = (longint'(g) * LEVEL_MAX + HALF_Q16) >> 16;
    return (v > LEVEL_MAX) ? level_t'(LEVEL_MAX) : level_t'(v);
  endfunction

  // Count one snapshot; on the window's last one update intensities and queue 14 half rows.
  task automatic absorb_snapshot(input snapshot_t snap);
    half_row_t hr;
    int lamp;
    for (int r = 0; r < USED_ROWS; r++)
      for (int l = 0; l < USED_LAMPS; l++)
        hits[r][l] += count_t'(snap[r][l]);
    window_pos++;
    if (window_pos < SAMPLES) return;
    window_pos = 0;
    for (int r = 0; r < USED_ROWS; r++)
      for (int l = 0; l < USED_LAMPS; l++)
        glow[r][l] = next_glow(glow[r][l], hits[r][l]);
    for (int r = 0; r < USED_ROWS; r++) begin
      for (int h = 0; h < 2; h++) begin
        hr.row = ROW_W'(r);
        hr.half = h[0];
        for (int j = 0; j < HALF_LAMPS; j++) begin
          lamp = h * HALF_LAMPS + j;
          hr.lvl[j] = (lamp < USED_LAMPS) ? glow_level(glow[r][lamp]) : '0;
        end
        hr.last = (r == USED_ROWS - 1) && (h == 1);
        due_half_rows.push_back(hr);
      end
    end
    hits = '{default: '0};
  endtask

  function automatic string describe(half_row_t hr);
    string s;
    s = $sformatf("row %0d half %0d levels", hr.row, hr.half);
    for (int j = 0; j < HALF_LAMPS; j++) s = {s, $sformatf(" %0d", hr.lvl[j])};
    return $sformatf("%s last %0d", s, hr.last);
  endfunction

  // Called at a rising edge; returns at the edge that accepted the snapshot.
  task automatic send_snapshot(input snapshot_t snap);
    int unsigned gap;
    gap = src_burst ? 0 : $urandom_range(0, IDLE_MAX);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata <= IN_DATA_W'(snap);
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    absorb_snapshot(snap);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val,
                           input bit more);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    // hold valid when another write follows right away
    if (!more) cfg_valid <= 1'b0;
    case (idx)
      REG_RISE_KEEP: keep_up = val;
      REG_FALL_KEEP: keep_down = val;
      default: ;
    endcase
  endtask

  // Drop the request, wait for every expected half row, then let the back end go quiet.
  task automatic settle_idle();
    s_tvalid <= 1'b0;
    while (due_half_rows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic pick_duties();
    for (int r = 0; r < MAX_ROWS; r++)
      for (int l = 0; l < MAX_LAMPS; l++)
        case ($urandom_range(0, 3))
          0: duty[r][l] = 0;
          1: duty[r][l] = SAMPLES;
          2: duty[r][l] = $urandom_range(0, SAMPLES);
          default: ;
        endcase
  endtask

  function automatic snapshot_t random_snapshot();
    snapshot_t snap;
    for (int r = 0; r < MAX_ROWS; r++)
      for (int l = 0; l < MAX_LAMPS; l++)
        snap[r][l] = $urandom_range(0, SAMPLES - 1) < duty[r][l];
    return snap;
  endfunction

  task automatic run_snapshots(input int unsigned count, input bit steady);
    for (int i = 0; i < count; i++) begin
      if (!steady && (i % 128) == 0) begin
        src_burst = ($urandom_range(0, 3) == 0);
        sink_burst <= ($urandom_range(0, 3) == 0);
      end
      send_snapshot(random_snapshot());
    end
  endtask

  task automatic test_directed_edges();
    snapshot_t snap;
    send_snapshot('0);
    send_snapshot('1);
    send_snapshot({MAX_ROWS{18'h2AAAA}});
    send_snapshot({MAX_ROWS{18'h15555}});
    send_snapshot({MAX_ROWS{18'h00001}});
    send_snapshot({MAX_ROWS{18'h20000}});
    for (int r = 0; r < MAX_ROWS; r++) begin
      snap = '0;
      snap[r] = '1;
      send_snapshot(snap);
    end
    for (int r = 0; r < MAX_ROWS; r++) snap[r] = lamp_row_t'(1) << (r * 2 + 3);
    send_snapshot(snap);
  endtask

  task automatic test_default_window();
    pick_duties();
    run_snapshots(SAMPLES - window_pos, 1'b0);
    settle_idle();
  endtask

  task automatic test_instant_rise();
    cfg_write(REG_RISE_KEEP, '0, 1'b1);
    cfg_write(REG_FALL_KEEP, CFG_DATA_W'(ONE_Q16), 1'b0);
    pick_duties();
    run_snapshots(SAMPLES, 1'b0);
    settle_idle();
  endtask

  // Unknown indexes must leave both coefficients alone; values above one saturate.
  task automatic test_saturated_keep();
    cfg_write(REG_UNUSED_FIRST, '0, 1'b1);
    cfg_write(REG_UNUSED_LAST, '1, 1'b1);
    cfg_write(REG_RISE_KEEP, CFG_DATA_W'(KEEP_TOP), 1'b1);
    cfg_write(REG_FALL_KEEP, '0, 1'b0);
    pick_duties();
    run_snapshots(SAMPLES, 1'b0);
    settle_idle();
  endtask

  // Stall the results of one window while the next one closes, so the input backs up.
  task automatic test_backpressure();
    cfg_write(REG_RISE_KEEP, CFG_DATA_W'($urandom_range(0, ONE_Q16)), 1'b1);
    cfg_write(REG_FALL_KEEP, CFG_DATA_W'($urandom_range(ONE_Q16 + 1, KEEP_TOP)), 1'b0);
    pick_duties();
    run_snapshots(SAMPLES - 1, 1'b0);
    hold_req <= ~hold_req;
    src_burst = 1'b1;
    pick_duties();
    run_snapshots(SAMPLES + 1, 1'b1);
    src_burst = 1'b0;
    settle_idle();
  endtask

  task automatic test_random_tail();
    cfg_write(REG_RISE_KEEP, CFG_DATA_W'(ONE_Q16), 1'b1);
    cfg_write(REG_FALL_KEEP, CFG_DATA_W'($urandom_range(0, ONE_Q16)), 1'b0);
    pick_duties();
    run_snapshots(SAMPLES, 1'b0);
    settle_idle();
    cfg_write(REG_RISE_KEEP, CFG_DATA_W'($urandom_range(0, KEEP_TOP)), 1'b1);
    cfg_write(REG_FALL_KEEP, CFG_DATA_W'($urandom_range(0, KEEP_TOP)), 1'b0);
    pick_duties();
    run_snapshots(SAMPLES + $urandom_range(1, 300), 1'b0);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_edges();
    test_default_window();
    test_instant_rise();
    test_saturated_keep();
    test_backpressure();
    test_random_tail();
    settle_idle();
    if (mismatches == 0 && due_half_rows.size() == 0) begin
      $display("[lamp_glow_persistence_filter] OK");
    end else begin
      $display("[lamp_glow_persistence_filter] ERROR");
    end
    $finish;
  end

  // Result side: random gap after each request, plus one long hold on demand.
  always @(posedge clk) begin : result_sink
    int unsigned gap;
    if (rst) begin
      m_tready <= 1'b0;
      sink_wait <= 1;
      hold_left <= 0;
      hold_seen <= hold_req;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      if (hold_left == 1) m_tready <= 1'b1;
    end else if (m_tvalid && m_tready) begin
      gap = sink_burst ? 0 : $urandom_range(0, IDLE_MAX);
      if (gap != 0) begin
        m_tready <= 1'b0;
        sink_wait <= gap;
      end
    end else if (sink_wait != 0) begin
      sink_wait <= sink_wait - 1;
      if (sink_wait == 1) m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    half_row_t got, want;
    bit bad;
    if (!rst && m_tvalid && m_tready) begin
      got.row = m_tuser[ROW_W-1:0];
      got.half = m_tuser[ROW_W];
      got.last = m_tlast;
      for (int j = 0; j < HALF_LAMPS; j++) got.lvl[j] = m_tdata[j*LEVEL_W +: LEVEL_W];
      if (due_half_rows.size() == 0) begin
        if (mismatches < REPORT_MAX) $display("unexpected half row: %s", describe(got));
        mismatches++;
      end else begin
        want = due_half_rows.pop_front();
        bad = (got.row !== want.row) || (got.half !== want.half) || (got.last !== want.last);
        for (int j = 0; j < HALF_LAMPS; j++)
          if (got.lvl[j] !== want.lvl[j]) bad = 1'b1;
        if (bad) begin
          if (mismatches < REPORT_MAX)
            $display("half row mismatch: expected %s, actual %s", describe(want), describe(got));
          mismatches++;
        end
      end
    end
  end

  // End the run when no request moves on any channel for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("[lamp_glow_persistence_filter] ERROR");
    $finish;
  end

endmodule
